// ===== rtl/ldte_pkg.sv =====
// ============================================================================
// ldte_pkg
// Shared types, constants and calendar helpers for the local date/time to
// UTC epoch converter.
// ============================================================================
package ldte_pkg;

    localparam logic [11:0] YEAR_FIRST = 12'd2000;
    localparam logic [11:0] YEAR_LAST  = 12'd2099;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;

    // 1970-01-01 to 2000-01-01
    localparam logic [31:0] SECS_AT_2000  = 32'd946684800;
    localparam logic [31:0] SECS_YEAR     = 32'd31536000;
    localparam logic [31:0] SECS_LEAP     = 32'd31622400;

    localparam logic signed [4:0] TZ_MIN = -5'sd12;
    localparam logic signed [4:0] TZ_MAX = 5'sd14;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Accumulator control
    typedef struct packed {
        logic load;
        logic add;
        logic sub;
    } t_acc_ctl;

    // Gregorian length of a month; only valid for 2000..2099 where
    // divisibility by 4 decides leap years (2000 is a leap year).
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        if (m < 4'd1 || m > 4'd12) begin
            len = 5'd31;
        end else if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = MONTH_LEN[m - 4'd1];
        end
        return len;
    endfunction

endpackage

// ===== rtl/ldte_check.sv =====
// ============================================================================
// ldte_check
// Range check of a captured calendar date and time.
// ============================================================================
module ldte_check
    import ldte_pkg::*;
(
    input  logic [11:0] i_cal_year,
    input  logic [3:0]  i_cal_month,
    input  logic [4:0]  i_cal_day,
    input  logic [4:0]  i_cal_hour,
    input  logic [5:0]  i_cal_minute,
    output logic        o_valid
);

    logic       leap;
    logic [4:0] mlen;

    assign leap = (i_cal_year[1:0] == 2'b00);
    assign mlen = month_len(leap, i_cal_month);

    assign o_valid = (i_cal_year >= YEAR_FIRST) && (i_cal_year <= YEAR_LAST)
                  && (i_cal_month >= 4'd1) && (i_cal_month <= 4'd12)
                  && (i_cal_day >= 5'd1) && (i_cal_day <= mlen)
                  && (i_cal_hour <= 5'd23) && (i_cal_minute <= 6'd59);

endmodule

// ===== rtl/ldte_acc.sv =====
// ============================================================================
// ldte_acc
// Shared 32-bit add/subtract unit with its accumulator register.
// ============================================================================
module ldte_acc
    import ldte_pkg::*;
(
    input  logic        i_clk,
    input  t_acc_ctl    i_ctl,
    input  logic [31:0] i_operand,
    output logic [31:0] o_acc
);

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [31:0] addend;

    assign addend = i_ctl.sub ? ~i_operand : i_operand;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.load) begin
            n_acc = i_operand;
        end else if (i_ctl.add || i_ctl.sub) begin
            n_acc = r_acc + addend + {31'd0, i_ctl.sub};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/local_datetime_to_utc_epoch.sv =====
// ============================================================================
// local_datetime_to_utc_epoch
// Local calendar date/time (2000..2099, seconds zero) to UTC seconds since
// 1970-01-01, less a configurable whole-hour timezone offset.
// ============================================================================
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | start, busy            | i_cal_year/month/day/hour/minute
//  result   | o_done (1-cycle pulse) | o_utc_seconds, o_date_valid
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (tz offset)
//
//  Timing: a valid item's time from accept to the o_done pulse grows with
//  the year offset from 2000 and with the month, since the years and then
//  the months are walked through the one shared adder. An invalid item is reported from S_CHECK.
//  busy stays high from accept until o_done; start is taken when busy is low,
//  which already holds in the o_done cycle.
//  Reset (synchronous, i_rst_n low): offset 0, sequencer idle, no pulse.
//  The receiver cannot stall: o_done is high for one cycle; the payload holds.
//
module local_datetime_to_utc_epoch
    import ldte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item in
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_cal_year,
    input  logic [3:0]  i_cal_month,
    input  logic [4:0]  i_cal_day,
    input  logic [4:0]  i_cal_hour,
    input  logic [5:0]  i_cal_minute,
    // item out
    output logic        o_done,
    output logic [31:0] o_utc_seconds,
    output logic        o_date_valid,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // One-hot sequencer states
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_YEARS  = 9'b000000100,
        S_MONTHS = 9'b000001000,
        S_DAY    = 9'b000010000,
        S_HOUR   = 9'b000100000,
        S_MINUTE = 9'b001000000,
        S_TZ     = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // ------------------------------------------------------------------
    // Timezone register: 5-bit signed write, saturated to -12..14.
    // Single register, so every address decodes to it.
    // ------------------------------------------------------------------
    logic signed [4:0] r_tz, n_tz;
    logic signed [4:0] wr_tz;
    logic              cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_tz  = $signed(pwdata[4:0]);

    always_comb begin
        n_tz = r_tz;
        if (cfg_wr) begin
            if (wr_tz < TZ_MIN) begin
                n_tz = TZ_MIN;
            end else if (wr_tz > TZ_MAX) begin
                n_tz = TZ_MAX;
            end else begin
                n_tz = wr_tz;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = {{27{r_tz[4]}}, r_tz};

    logic unused_addr;
    assign unused_addr = ^paddr;

    // ------------------------------------------------------------------
    // Captured item
    // ------------------------------------------------------------------
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic        take;

    assign busy = (r_state != S_IDLE);
    assign take = start && !busy;

    // walk counters: years since 2000, current month
    logic [6:0] r_ycnt, n_ycnt;
    logic [3:0] r_mcnt, n_mcnt;
    logic [6:0] year_off;

    assign year_off = 7'(r_year - YEAR_FIRST);

    logic date_ok;

    ldte_check u_check (
        .i_cal_year   (r_year),
        .i_cal_month  (r_month),
        .i_cal_day    (r_day),
        .i_cal_hour   (r_hour),
        .i_cal_minute (r_minute),
        .o_valid      (date_ok)
    );

    // ------------------------------------------------------------------
    // Shared adder: operand select per sequencer step
    // ------------------------------------------------------------------
    t_acc_ctl          acc_ctl;
    logic [31:0]       operand;
    logic [31:0]       acc;
    logic [4:0]        mlen;
    logic signed [16:0] tz_secs;

    assign mlen    = month_len(r_year[1:0] == 2'b00, r_mcnt);
    assign tz_secs = 17'(r_tz * $signed(17'd3600));

    ldte_acc u_acc (
        .i_clk     (i_clk),
        .i_ctl     (acc_ctl),
        .i_operand (operand),
        .o_acc     (acc)
    );

    // result registers
    logic        r_done, n_done;
    logic [31:0] r_utc, n_utc;
    logic        r_vld, n_vld;

    always_comb begin
        n_state = r_state;
        n_ycnt  = r_ycnt;
        n_mcnt  = r_mcnt;
        n_done  = 1'b0;
        n_utc   = r_utc;
        n_vld   = r_vld;
        acc_ctl = '0;
        operand = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ycnt = '0;
                n_mcnt = 4'd1;
                if (date_ok) begin
                    acc_ctl.load = 1'b1;
                    operand      = SECS_AT_2000;
                    n_state      = S_YEARS;
                end else begin
                    n_done  = 1'b1;
                    n_utc   = '0;
                    n_vld   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_YEARS: begin
                if (r_ycnt == year_off) begin
                    n_state = S_MONTHS;
                end else begin
                    acc_ctl.add = 1'b1;
                    operand     = (r_ycnt[1:0] == 2'b00) ? SECS_LEAP : SECS_YEAR;
                    n_ycnt      = r_ycnt + 7'd1;
                end
            end
            S_MONTHS: begin
                if (r_mcnt == r_month) begin
                    n_state = S_DAY;
                end else begin
                    acc_ctl.add = 1'b1;
                    operand     = 32'(mlen) * SECS_PER_DAY;
                    n_mcnt      = r_mcnt + 4'd1;
                end
            end
            S_DAY: begin
                acc_ctl.add = 1'b1;
                operand     = 32'(r_day - 5'd1) * SECS_PER_DAY;
                n_state     = S_HOUR;
            end
            S_HOUR: begin
                acc_ctl.add = 1'b1;
                operand     = 32'(r_hour) * SECS_PER_HOUR;
                n_state     = S_MINUTE;
            end
            S_MINUTE: begin
                acc_ctl.add = 1'b1;
                operand     = 32'(r_minute) * SECS_PER_MIN;
                n_state     = S_TZ;
            end
            S_TZ: begin
                // local minus offset gives UTC; never leaves 32-bit range
                acc_ctl.sub = 1'b1;
                operand     = {{15{tz_secs[16]}}, tz_secs};
                n_state     = S_DONE;
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_utc   = acc;
                n_vld   = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tz    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tz    <= n_tz;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_year   <= i_cal_year;
            r_month  <= i_cal_month;
            r_day    <= i_cal_day;
            r_hour   <= i_cal_hour;
            r_minute <= i_cal_minute;
        end
        r_ycnt <= n_ycnt;
        r_mcnt <= n_mcnt;
        r_utc  <= n_utc;
        r_vld  <= n_vld;
    end

    assign o_done        = r_done;
    assign o_utc_seconds = r_utc;
    assign o_date_valid  = r_vld;

endmodule

// ===== dv/local_datetime_to_utc_epoch_tb.sv =====
// ============================================================================
// local_datetime_to_utc_epoch_tb
// Self-checking bench: local date/time items in, UTC seconds checked against
// an in-bench calendar predictor across several timezone offset settings.
// ============================================================================
module local_datetime_to_utc_epoch_tb
    import ldte_pkg::*;
();

    // Register map: the timezone offset is the only register, at byte 0.
    localparam logic [1:0] TZ_OFFSET_ADDR = 2'd0;
    // Idle cycles without an accepted item or result before we give up.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 130;
    localparam int ITEMS_PER_PHASE = 140;

    typedef struct {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_cal_item;

    typedef struct {
        logic [31:0] secs;
        logic        date_valid;
    } t_utc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] i_cal_year = '0;
    logic [3:0]  i_cal_month = '0;
    logic [4:0]  i_cal_day = '0;
    logic [4:0]  i_cal_hour = '0;
    logic [5:0]  i_cal_minute = '0;
    logic        o_done;
    logic [31:0] o_utc_seconds;
    logic        o_date_valid;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    local_datetime_to_utc_epoch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cal_year    (i_cal_year),
        .i_cal_month   (i_cal_month),
        .i_cal_day     (i_cal_day),
        .i_cal_hour    (i_cal_hour),
        .i_cal_minute  (i_cal_minute),
        .o_done        (o_done),
        .o_utc_seconds (o_utc_seconds),
        .o_date_valid  (o_date_valid),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the offset register, updated after each register write.
    logic signed [4:0] tz_hours = '0;

    t_cal_item   pending_dates[$];   // items waiting for the driver
    t_utc_result expected_utc[$];    // predictions for accepted items, in order
    t_cal_item   cur_date;           // item currently on the input ports
    int          dates_queued = 0;
    int          dates_accepted = 0;
    int          errors = 0;
    int          gap_left = 0;
    bit          gap_on_idle = 1'b0; // gap counts only while the block is idle
    bit          gaps_on = 1'b1;     // cleared for the last phase
    int          quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------
    // Full Gregorian rule, also applied to the years before 2000 that feed
    // the day count.
    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        int unsigned len;
        case (m)
            2:          len = is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default:    len = 31;
        endcase
        return len;
    endfunction

    function automatic t_utc_result predict_utc(t_cal_item c, logic signed [4:0] tz);
        t_utc_result r;
        int unsigned days;
        int unsigned y;
        int unsigned m;
        longint      secs;
        r.secs = '0;
        r.date_valid = 1'b0;
        if (c.year < 2000 || c.year > 2099 || c.month < 1 || c.month > 12 ||
            c.day < 1 || c.day > days_in_month(c.year, c.month) ||
            c.hour > 23 || c.minute > 59) begin
            return r;
        end
        days = 0;
        for (y = 1970; y < c.year; y++) begin
            days += is_leap_year(y) ? 366 : 365;
        end
        for (m = 1; m < c.month; m++) begin
            days += days_in_month(c.year, m);
        end
        days += c.day - 1;
        secs = longint'(days) * 86400 + longint'(c.hour) * 3600 +
               longint'(c.minute) * 60 - longint'(tz) * 3600;
        if (secs < 0) begin
            secs = 0;
        end
        if (secs > 64'sh0_FFFF_FFFF) begin
            secs = 64'sh0_FFFF_FFFF;
        end
        r.secs = secs[31:0];
        r.date_valid = 1'b1;
        return r;
    endfunction

    // Register semantics: low 5 bits sign extended, saturated to -12..14.
    function automatic logic signed [4:0] clamp_tz(logic [31:0] data);
        logic signed [4:0] raw;
        raw = data[4:0];
        if (raw < TZ_MIN) begin
            raw = TZ_MIN;
        end
        if (raw > TZ_MAX) begin
            raw = TZ_MAX;
        end
        return raw;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_date(int y, int mo, int d, int h, int mi);
        t_cal_item c;
        c.year = 12'(y);
        c.month = 4'(mo);
        c.day = 5'(d);
        c.hour = 5'(h);
        c.minute = 6'(mi);
        pending_dates.push_back(c);
        dates_queued++;
    endtask

    // Mostly well-formed dates with random content; the rest is raw noise or
    // a date with exactly one field pushed outside its legal range.
    function automatic t_cal_item random_date();
        t_cal_item   c;
        int unsigned dim;
        c.year = 12'($urandom_range(2000, 2099));
        c.month = 4'($urandom_range(1, 12));
        dim = days_in_month(c.year, c.month);
        c.day = 5'(($urandom_range(0, 7) == 0) ? dim : $urandom_range(1, dim));
        c.hour = 5'($urandom_range(0, 23));
        c.minute = 6'($urandom_range(0, 59));
        case ($urandom_range(0, 19))
            15: begin
                c.year = 12'($urandom);
                c.month = 4'($urandom);
                c.day = 5'($urandom);
                c.hour = 5'($urandom);
                c.minute = 6'($urandom);
            end
            16: begin
                c.year = 12'($urandom_range(0, 1) ? $urandom_range(0, 1999)
                                                  : $urandom_range(2100, 4095));
            end
            17: begin
                c.month = 4'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
            end
            18: begin
                c.day = 5'((dim == 31 || $urandom_range(0, 3) == 0)
                           ? 0 : $urandom_range(dim + 1, 31));
            end
            19: begin
                if ($urandom_range(0, 1)) begin
                    c.hour = 5'($urandom_range(24, 31));
                end else begin
                    c.minute = 6'($urandom_range(60, 63));
                end
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic add_random_dates(int n);
        repeat (n) begin
            pending_dates.push_back(random_date());
            dates_queued++;
        end
    endtask

    // Sender holds off until every accepted item has produced its result.
    task automatic wait_until_idle();
        while (dates_accepted != dates_queued || expected_utc.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Two-phase register write; the register updates at the access edge.
    task automatic write_tz_offset(logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TZ_OFFSET_ADDR;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tz_hours = clamp_tz(data);
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the next pending item, holds it while busy, and
    // inserts random gaps after accepts (raw or counted only while idle).
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                expected_utc.push_back(predict_utc(cur_date, tz_hours));
                dates_accepted++;
                if (gaps_on && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 10);
                    gap_on_idle = ($urandom_range(0, 1) == 1);
                end
            end
            if (start && busy) begin
                // item still waiting; keep it on the ports
            end else if (gap_left > 0) begin
                if (!gap_on_idle || !busy) begin
                    gap_left--;
                end
                start <= 1'b0;
            end else if (pending_dates.size() > 0) begin
                cur_date = pending_dates.pop_front();
                i_cal_year <= cur_date.year;
                i_cal_month <= cur_date.month;
                i_cal_day <= cur_date.day;
                i_cal_hour <= cur_date.hour;
                i_cal_minute <= cur_date.minute;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every o_done pulse is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    t_utc_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_utc.size() == 0) begin
                errors++;
                $display({"%0t: unexpected result: expected none, ",
                          "actual utc_seconds=%0d date_valid=%0b"},
                         $time, o_utc_seconds, o_date_valid);
            end else begin
                want = expected_utc.pop_front();
                if (o_utc_seconds !== want.secs) begin
                    errors++;
                    $display("%0t: utc_seconds mismatch: expected %0d actual %0d",
                             $time, want.secs, o_utc_seconds);
                end
                if (o_date_valid !== want.date_valid) begin
                    errors++;
                    $display("%0t: date_valid mismatch: expected %0b actual %0b",
                             $time, want.date_valid, o_date_valid);
                end
            end
        end
    end

    // Watchdog: any accepted item or result counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, expected_utc.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    // Offset settings after the reset phase: both bounds, values that must
    // saturate (15, -16, -13), a few ordinary ones, and one random pattern.
    logic [4:0] tz_settings[9] = '{
        5'd14, 5'b10100, 5'd15, 5'b10000, 5'b10011, 5'b11111, 5'd1, 5'd9, 5'd0
    };

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset offset of zero.
        add_date(2000, 1, 1, 0, 0);       // first second of the range
        add_date(2099, 12, 31, 23, 59);   // last minute of the range
        add_date(1999, 12, 31, 23, 59);   // year just below
        add_date(2100, 1, 1, 0, 0);       // year just above
        add_date(0, 0, 0, 0, 0);          // all fields zero
        add_date(4095, 15, 31, 31, 63);   // all field bits set
        add_date(2050, 0, 10, 12, 30);    // month zero
        add_date(2050, 13, 10, 12, 30);   // month just above
        add_date(2050, 6, 0, 12, 30);     // day zero
        add_date(2001, 4, 31, 8, 0);      // 31st of a 30 day month
        add_date(2001, 4, 30, 8, 0);      // last day of a 30 day month
        add_date(2024, 1, 31, 1, 1);      // last day of a 31 day month
        add_date(2000, 2, 29, 6, 15);     // leap day in a century leap year
        add_date(2004, 2, 29, 18, 45);    // leap day in an ordinary leap year
        add_date(2001, 2, 29, 6, 15);     // leap day in a common year
        add_date(2000, 2, 30, 6, 15);     // past the leap day
        add_date(2099, 2, 28, 23, 0);     // last day of February, common year
        add_date(2010, 7, 4, 23, 59);     // largest hour and minute
        add_date(2010, 7, 4, 24, 0);      // hour just above
        add_date(2010, 7, 4, 31, 0);      // hour all ones
        add_date(2010, 7, 4, 0, 60);      // minute just above
        add_date(2010, 7, 4, 0, 63);      // minute all ones
        add_random_dates(ITEMS_PER_PHASE);
        wait_until_idle();

        tz_settings[8] = 5'($urandom);
        foreach (tz_settings[i]) begin
            // Upper data bits are random; only the low five carry the offset.
            write_tz_offset({27'($urandom), tz_settings[i]});
            if (i == 8) begin
                gaps_on = 1'b0;
            end
            add_random_dates(ITEMS_PER_PHASE);
            wait_until_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_utc.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
